/* design/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg: shared constants and types of the cuckoo hash table core
// Field widths, status and register codes, datapath operation codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int KEY_W       = 64;
   localparam int CAP_W       = 11;
   localparam int LEN_W       = 4;
   localparam int KICK_W      = 5;
   localparam int STAT_W      = 3;
   localparam int CNT_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int DEF_TABLE_DEPTH   = 1024;
   localparam int DEF_KEY_MAX_BYTES = 8;
   localparam int DEF_DATA_WIDTH    = 32;

   localparam logic [CAP_W-1:0]  RST_CAPACITY   = CAP_W'(1021);
   localparam logic [LEN_W-1:0]  RST_KEY_BYTES  = LEN_W'(8);
   localparam logic [KICK_W-1:0] RST_KICK_LIMIT = KICK_W'(9);

   localparam logic [63:0] DJB_SEED  = 64'd5381;
   localparam logic [63:0] SDBM_SEED = 64'd65599;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KICK_LIMIT = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_FAILED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
   localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
   localparam logic [OP_W-1:0] OP_HASH_NEW    = 4'd2;
   localparam logic [OP_W-1:0] OP_HASH_CARRY  = 4'd3;
   localparam logic [OP_W-1:0] OP_READ_BOTH   = 4'd4;
   localparam logic [OP_W-1:0] OP_READ_SIDE   = 4'd5;
   localparam logic [OP_W-1:0] OP_LOOKUP_RES  = 4'd6;
   localparam logic [OP_W-1:0] OP_UPD1        = 4'd7;
   localparam logic [OP_W-1:0] OP_UPD2        = 4'd8;
   localparam logic [OP_W-1:0] OP_PLACE_NEW   = 4'd9;
   localparam logic [OP_W-1:0] OP_EVICT_NEW   = 4'd10;
   localparam logic [OP_W-1:0] OP_SPILL       = 4'd11;
   localparam logic [OP_W-1:0] OP_PLACE_CARRY = 4'd12;
   localparam logic [OP_W-1:0] OP_SWAP        = 4'd13;
   localparam logic [OP_W-1:0] OP_EMIT        = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic hash_done;
      logic is_lookup;
      logic hit1;
      logic hit2;
      logic valid1;
      logic valid_side;
      logic over_limit;
      logic rsp_free;
   } stat_type;

endpackage

/* design/cuckoo_hash_table_core.sv */
// ----------------------------------------------------------------------------
// cuckoo_hash_table_core: two-table cuckoo hash map
// Insert, update and lookup of fixed-width byte keys with a bounded
// displacement chain; one result word per request word.
// ----------------------------------------------------------------------------
// Each request word is handled alone. Both slot indices come from one shared
// hash unit that hashes the key one byte a cycle and then reduces both hashes
// modulo capacity one bit a cycle, so a lookup, an update or an insert into an
// empty slot passes through hashing, a read of both tables and the decision
// before the next request word is accepted, and every displacement adds one
// more pass through the hash unit and a table read. After reset the tables
// are swept clear, one entry of each table per cycle, during which req_ready
// stays low; configuration writes are taken at any time (csr_ready is always
// high) but must only be issued while the core is idle. A finished result
// waits in the output register while the next request word is already
// accepted.
module cuckoo_hash_table_core import cht_pkg::*; #(
   parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
   parameter int KEY_MAX_BYTES = DEF_KEY_MAX_BYTES,
   parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [DATA_WIDTH-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [KEY_W-1:0]      rsp_spilled_key,
   output logic [DATA_WIDTH-1:0] rsp_spilled_value,
   output logic [CNT_W-1:0]      rsp_entry_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // configuration never stalls
   assign csr_ready = 1'b1;

   // sequencing: one datapath operation per cycle
   cht_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // tables, hash unit, working and result registers
   cht_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .KEY_MAX_BYTES(KEY_MAX_BYTES),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_spilled_key  (rsp_spilled_key),
      .rsp_spilled_value(rsp_spilled_value),
      .rsp_entry_count  (rsp_entry_count),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

/* design/cht_hash.sv */
// ----------------------------------------------------------------------------
// cht_hash: byte-serial dual hash with bit-serial reduction
// Hashes the key one byte a cycle (djb2-xor and sdbm, 64-bit wrap), then
// reduces both hashes modulo the capacity one bit a cycle.
// ----------------------------------------------------------------------------
module cht_hash import cht_pkg::*; #(
   parameter int KEY_MAX_BYTES = DEF_KEY_MAX_BYTES,
   parameter int IDX_W         = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [8*KEY_MAX_BYTES-1:0] key,
   input  logic [LEN_W-1:0]           len,
   input  logic [CAP_W-1:0]           cap,
   output logic                       done,
   output logic [IDX_W-1:0]           idx1,
   output logic [IDX_W-1:0]           idx2
);

   localparam int KW = 8 * KEY_MAX_BYTES;
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BYTE = 2'd1;
   localparam logic [1:0] PH_MOD  = 2'd2;

   logic [1:0]       ph_ff, ph_in;
   logic [63:0]      h1_ff, h1_in, h2_ff, h2_in;
   logic [KW-1:0]    ks_ff, ks_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [5:0]       bit_ff, bit_in;
   logic [CAP_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic             done_ff, done_in;
   logic [63:0]      b;
   logic [CAP_W:0]   t1, t2;

   always_comb begin
      ph_in   = ph_ff;
      h1_in   = h1_ff;
      h2_in   = h2_ff;
      ks_in   = ks_ff;
      n_in    = n_ff;
      bit_in  = bit_ff;
      r1_in   = r1_ff;
      r2_in   = r2_ff;
      done_in = 1'b0;
      b       = {56'd0, ks_ff[7:0]};
      t1      = {r1_ff, h1_ff[63]};
      t2      = {r2_ff, h2_ff[63]};
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               h1_in = DJB_SEED;
               h2_in = SDBM_SEED;
               ks_in = key;
               n_in  = len;
               ph_in = PH_BYTE;
            end
         end
         PH_BYTE: begin
            h1_in = ((h1_ff << 5) + h1_ff) ^ b;
            h2_in = b + (h2_ff << 6) + (h2_ff << 16) - h2_ff;
            ks_in = ks_ff >> 8;
            n_in  = n_ff - LEN_W'(1);
            if (n_ff <= LEN_W'(1)) begin
               ph_in  = PH_MOD;
               bit_in = '0;
               r1_in  = '0;
               r2_in  = '0;
            end
         end
         PH_MOD: begin
            r1_in  = (t1 >= {1'b0, cap}) ? CAP_W'(t1 - {1'b0, cap}) : t1[CAP_W-1:0];
            r2_in  = (t2 >= {1'b0, cap}) ? CAP_W'(t2 - {1'b0, cap}) : t2[CAP_W-1:0];
            h1_in  = h1_ff << 1;
            h2_in  = h2_ff << 1;
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd63) begin
               ph_in   = PH_IDLE;
               done_in = 1'b1;
            end
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      h1_ff  <= h1_in;
      h2_ff  <= h2_in;
      ks_ff  <= ks_in;
      n_ff   <= n_in;
      bit_ff <= bit_in;
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
   end

   assign done = done_ff;
   assign idx1 = IDX_W'(r1_ff);
   assign idx2 = IDX_W'(r2_ff);

endmodule

/* design/cht_datapath.sv */
// ----------------------------------------------------------------------------
// cht_datapath: tables, configuration, working registers and result words
// Carries out one operation a cycle as the controller commands.
// ----------------------------------------------------------------------------
module cht_datapath import cht_pkg::*; #(
   parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
   parameter int KEY_MAX_BYTES = DEF_KEY_MAX_BYTES,
   parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  req_kind,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [DATA_WIDTH-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [KEY_W-1:0]      rsp_spilled_key,
   output logic [DATA_WIDTH-1:0] rsp_spilled_value,
   output logic [CNT_W-1:0]      rsp_entry_count,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int KW      = 8 * KEY_MAX_BYTES;
   localparam int EW      = 1 + KW + DATA_WIDTH;
   localparam int CAP_LIM = (TABLE_DEPTH < 2048) ? TABLE_DEPTH : 2047;

   logic [CAP_W-1:0]  cap_ff;
   logic [LEN_W-1:0]  klen_ff;
   logic [KICK_W-1:0] kick_ff;
   logic [CAP_W-1:0]  cap_eff;
   logic [LEN_W-1:0]  len_eff;
   logic [KW-1:0]     mask;

   logic [EW-1:0]     mem1 [TABLE_DEPTH];
   logic [EW-1:0]     mem2 [TABLE_DEPTH];
   logic [EW-1:0]     rd1_ff, rd2_ff, wd1, wd2;
   logic [IDX_W-1:0]  a1, a2;
   logic              we1, we2, re1, re2;
   logic [IDX_W-1:0]  clr_ff;
   logic              clr_busy_ff;

   logic              kind_ff;
   logic [KW-1:0]     key_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [KW-1:0]     ck_ff;
   logic [DATA_WIDTH-1:0] cv_ff;
   logic              side2_ff;
   logic [KICK_W:0]   kicks_ff;
   logic [CNT_W-1:0]  count_ff;

   logic [STAT_W-1:0]     res_st_ff;
   logic [DATA_WIDTH-1:0] res_rd_ff, res_sv_ff;
   logic [KW-1:0]         res_sk_ff;
   logic                  rsp_valid_ff;

   logic              h_start, h_done;
   logic [KW-1:0]     h_key;
   logic [IDX_W-1:0]  idx1, idx2;
   logic              carry_op;
   logic [EW-1:0]     new_entry, carry_entry;

   // effective configuration
   always_comb begin
      if (cap_ff == '0)
         cap_eff = CAP_W'(1);
      else if ({21'd0, cap_ff} > 32'(CAP_LIM))
         cap_eff = CAP_W'(CAP_LIM);
      else
         cap_eff = cap_ff;
      if (klen_ff == '0)
         len_eff = LEN_W'(1);
      else if ({28'd0, klen_ff} > 32'(KEY_MAX_BYTES))
         len_eff = LEN_W'(KEY_MAX_BYTES);
      else
         len_eff = klen_ff;
      for (int i = 0; i < KEY_MAX_BYTES; i++)
         mask[8*i +: 8] = ({28'd0, len_eff} > 32'(i)) ? 8'hFF : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= RST_CAPACITY;
         klen_ff <= RST_KEY_BYTES;
         kick_ff <= RST_KICK_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY:   cap_ff  <= csr_data[CAP_W-1:0];
            CSR_KEY_BYTES:  klen_ff <= csr_data[LEN_W-1:0];
            CSR_KICK_LIMIT: kick_ff <= csr_data[KICK_W-1:0];
            default: ;
         endcase
      end
   end

   assign h_start = (cmd.op == OP_HASH_NEW) || (cmd.op == OP_HASH_CARRY);
   assign h_key   = (cmd.op == OP_HASH_CARRY) ? ck_ff : key_ff;

   cht_hash #(
      .KEY_MAX_BYTES(KEY_MAX_BYTES),
      .IDX_W        (IDX_W)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(h_start),
      .key  (h_key),
      .len  (len_eff),
      .cap  (cap_eff),
      .done (h_done),
      .idx1 (idx1),
      .idx2 (idx2)
   );

   // table ports
   assign new_entry   = {1'b1, key_ff, val_ff};
   assign carry_entry = {1'b1, ck_ff, cv_ff};
   assign carry_op    = (cmd.op == OP_SWAP) || (cmd.op == OP_PLACE_CARRY);

   always_comb begin
      a1  = clr_busy_ff ? clr_ff : idx1;
      a2  = clr_busy_ff ? clr_ff : idx2;
      we1 = 1'b0;
      we2 = 1'b0;
      wd1 = new_entry;
      wd2 = new_entry;
      re1 = (cmd.op == OP_READ_BOTH) || ((cmd.op == OP_READ_SIDE) && !side2_ff);
      re2 = (cmd.op == OP_READ_BOTH) || ((cmd.op == OP_READ_SIDE) && side2_ff);
      if (clr_busy_ff) begin
         we1 = 1'b1;
         we2 = 1'b1;
         wd1 = '0;
         wd2 = '0;
      end else begin
         case (cmd.op)
            OP_UPD1: begin
               we1 = 1'b1;
               wd1 = {1'b1, rd1_ff[EW-2 -: KW], val_ff};
            end
            OP_UPD2: begin
               we2 = 1'b1;
               wd2 = {1'b1, rd2_ff[EW-2 -: KW], val_ff};
            end
            OP_PLACE_NEW, OP_EVICT_NEW: we1 = 1'b1;
            default: begin
               if (carry_op) begin
                  we1 = !side2_ff;
                  we2 = side2_ff;
                  wd1 = carry_entry;
                  wd2 = carry_entry;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we1)
         mem1[a1] <= wd1;
      if (re1)
         rd1_ff <= mem1[a1];
   end

   always_ff @(posedge clock) begin
      if (we2)
         mem2[a2] <= wd2;
      if (re2)
         rd2_ff <= mem2[a2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clr_busy_ff) begin
         clr_ff <= clr_ff + IDX_W'(1);
         if (clr_ff == IDX_W'(TABLE_DEPTH - 1))
            clr_busy_ff <= 1'b0;
      end
   end

   // working registers and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((cmd.op == OP_PLACE_NEW) || (cmd.op == OP_PLACE_CARRY))
            count_ff <= count_ff + CNT_W'(1);
         if (cmd.op == OP_EMIT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
      case (cmd.op)
         OP_LOAD: begin
            kind_ff   <= req_kind;
            key_ff    <= req_key[KW-1:0] & mask;
            val_ff    <= req_value;
            res_st_ff <= ST_MISS;
            res_rd_ff <= '0;
            res_sk_ff <= '0;
            res_sv_ff <= '0;
         end
         OP_LOOKUP_RES: begin
            if (stat.hit1) begin
               res_st_ff <= ST_HIT;
               res_rd_ff <= rd1_ff[DATA_WIDTH-1:0];
            end else if (stat.hit2) begin
               res_st_ff <= ST_HIT;
               res_rd_ff <= rd2_ff[DATA_WIDTH-1:0];
            end else begin
               res_st_ff <= ST_MISS;
            end
         end
         OP_UPD1, OP_UPD2: res_st_ff <= ST_UPDATED;
         OP_PLACE_NEW, OP_PLACE_CARRY: res_st_ff <= ST_INSERTED;
         OP_EVICT_NEW: begin
            ck_ff    <= rd1_ff[EW-2 -: KW];
            cv_ff    <= rd1_ff[DATA_WIDTH-1:0];
            kicks_ff <= (KICK_W+1)'(1);
            side2_ff <= 1'b1;
         end
         OP_SWAP: begin
            ck_ff    <= side2_ff ? rd2_ff[EW-2 -: KW] : rd1_ff[EW-2 -: KW];
            cv_ff    <= side2_ff ? rd2_ff[DATA_WIDTH-1:0] : rd1_ff[DATA_WIDTH-1:0];
            kicks_ff <= kicks_ff + (KICK_W+1)'(1);
            side2_ff <= !side2_ff;
         end
         OP_SPILL: begin
            res_st_ff <= ST_FAILED;
            res_sk_ff <= ck_ff;
            res_sv_ff <= cv_ff;
         end
         OP_EMIT: begin
            rsp_status        <= res_st_ff;
            rsp_read_value    <= res_rd_ff;
            rsp_spilled_key   <= KEY_W'(res_sk_ff);
            rsp_spilled_value <= res_sv_ff;
            rsp_entry_count   <= count_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.clearing   = clr_busy_ff;
      stat.hash_done  = h_done;
      stat.is_lookup  = kind_ff;
      stat.hit1       = rd1_ff[EW-1] && (rd1_ff[EW-2 -: KW] == key_ff);
      stat.hit2       = rd2_ff[EW-1] && (rd2_ff[EW-2 -: KW] == key_ff);
      stat.valid1     = rd1_ff[EW-1];
      stat.valid_side = side2_ff ? rd2_ff[EW-1] : rd1_ff[EW-1];
      stat.over_limit = kicks_ff > {1'b0, kick_ff};
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

/* design/cht_ctrl.sv */
// ----------------------------------------------------------------------------
// cht_ctrl: sequencing state machine
// Walks each word through hashing, table reads, the decision and the
// displacement chain, and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module cht_ctrl import cht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HNEW  = 4'd1;
   localparam logic [3:0] S_HWAIT = 4'd2;
   localparam logic [3:0] S_READ  = 4'd3;
   localparam logic [3:0] S_DEC   = 4'd4;
   localparam logic [3:0] S_KICK  = 4'd5;
   localparam logic [3:0] S_KWAIT = 4'd6;
   localparam logic [3:0] S_KREAD = 4'd7;
   localparam logic [3:0] S_KDEC  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && !stat.clearing;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.op   = OP_LOAD;
               state_in = S_HNEW;
            end
         end
         S_HNEW: begin
            cmd.op   = OP_HASH_NEW;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (stat.hash_done)
               state_in = S_READ;
         end
         S_READ: begin
            cmd.op   = OP_READ_BOTH;
            state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_DONE;
            if (stat.is_lookup)
               cmd.op = OP_LOOKUP_RES;
            else if (stat.hit1)
               cmd.op = OP_UPD1;
            else if (stat.hit2)
               cmd.op = OP_UPD2;
            else if (!stat.valid1)
               cmd.op = OP_PLACE_NEW;
            else begin
               cmd.op   = OP_EVICT_NEW;
               state_in = S_KICK;
            end
         end
         S_KICK: begin
            if (stat.over_limit) begin
               cmd.op   = OP_SPILL;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_HASH_CARRY;
               state_in = S_KWAIT;
            end
         end
         S_KWAIT: begin
            if (stat.hash_done)
               state_in = S_KREAD;
         end
         S_KREAD: begin
            cmd.op   = OP_READ_SIDE;
            state_in = S_KDEC;
         end
         S_KDEC: begin
            if (stat.valid_side) begin
               cmd.op   = OP_SWAP;
               state_in = S_KICK;
            end else begin
               cmd.op   = OP_PLACE_CARRY;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

/* design/cht_checker.sv */
// ----------------------------------------------------------------------------
// cht_checker: port-level checks of the cuckoo hash table core
// Watches the request and result channels and the result word contents.
// ----------------------------------------------------------------------------
module cht_checker import cht_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STAT_W-1:0]     rsp_status,
   input logic [DATA_WIDTH-1:0] rsp_read_value,
   input logic [KEY_W-1:0]      rsp_spilled_key,
   input logic [DATA_WIDTH-1:0] rsp_spilled_value
);

   // a stalled result word stays valid with its status and read value held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value))
      else $error("result word changed while stalled");

   // one word in flight: no acceptance on the cycle after one
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // read data only on a hit
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_HIT) |-> rsp_read_value == '0)
      else $error("read data without a hit");

   // spilled entry only on a failed insert
   a_spill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FAILED) |->
         (rsp_spilled_key == '0) && (rsp_spilled_value == '0))
      else $error("spilled entry without a failed insert");

endmodule

bind cuckoo_hash_table_core cht_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
